// ----- rtl/cslf_pkg.sv -----
`default_nettype none
package cslf_pkg;

	localparam int UNIT_Q14 = 16384;

	typedef struct packed {
		logic signed [31:0] centre_x;
		logic signed [31:0] centre_y;
		logic signed [31:0] centre_z;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] first_x;
		logic signed [15:0] first_y;
		logic signed [15:0] first_z;
		logic signed [15:0] second_x;
		logic signed [15:0] second_y;
		logic signed [15:0] second_z;
		logic signed [15:0] third_x;
		logic signed [15:0] third_y;
		logic signed [15:0] third_z;
		logic [1:0]         frame_status;
	} out_item_t;

	typedef enum logic [2:0] {
		REG_FRAME_MODE = 3'd0,
		REG_AXIS_X     = 3'd1,
		REG_AXIS_Y     = 3'd2,
		REG_AXIS_Z     = 3'd3,
		REG_ORIGIN_X   = 3'd4,
		REG_ORIGIN_Y   = 3'd5,
		REG_ORIGIN_Z   = 3'd6,
		REG_NEAR_ZERO  = 3'd7
	} reg_index_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_AXIS_ZERO = 2'd1,
		ST_DEGEN     = 2'd2
	} status_t;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] axis_x;
		logic signed [31:0] axis_y;
		logic signed [31:0] axis_z;
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic [14:0]        lim;
	} cfg_t;

	// one classified request waiting for the back end
	typedef struct packed {
		logic               mode;
		logic               axis_zero;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [32:0] dz;
	} job_t;

	typedef logic signed [63:0] wide_t;
	typedef logic signed [15:0] q14_t;

	typedef struct packed {
		logic done;
		logic zero;
	} norm_rsp_t;

	typedef enum logic [2:0] {
		N_IDLE, N_SHIFT, N_SQ, N_ROOT, N_DSET, N_DIV, N_DONE
	} norm_state_t;

	typedef enum logic [3:0] {
		EX_IDLE, EX_LAUNCH, EX_WAIT, EX_DOT, EX_SCL, EX_PROJ, EX_CRS,
		EX_ND, EX_TST, EX_TV, EX_NEG, EX_DONE
	} exec_state_t;

	typedef enum logic [2:0] {
		PH_AXIS_C, PH_RAD, PH_SPH1, PH_SPH2, PH_THIRD
	} phase_t;

endpackage
`default_nettype wire

// ----- rtl/cslf_front.sv -----
`default_nettype none
module cslf_front (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  cslf_pkg::in_item_t item,
	input  cslf_pkg::cfg_t    cfg,
	input  wire               pop,
	output cslf_pkg::job_t    job,
	output logic              job_valid
);
	import cslf_pkg::*;

	logic [1:0] count_q;
	logic       wr_q;
	logic       rd_q;
	logic       push;
	job_t       slot_q [2];
	job_t       job_in;

	assign busy      = (count_q == 2'd2);
	assign push      = start && !busy;
	assign job_valid = (count_q != 2'd0);
	assign job       = slot_q[rd_q];

	// classify: mode, zero axis, offset from origin
	always_comb begin
		job_in.mode      = cfg.mode;
		job_in.axis_zero = (cfg.axis_x == '0) && (cfg.axis_y == '0) && (cfg.axis_z == '0);
		job_in.dx        = 33'(item.centre_x) - 33'(cfg.origin_x);
		job_in.dy        = 33'(item.centre_y) - 33'(cfg.origin_y);
		job_in.dz        = 33'(item.centre_z) - 33'(cfg.origin_z);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
		end else begin
			count_q <= count_q + 2'(push) - 2'(pop);
			if (push) wr_q <= !wr_q;
			if (pop)  rd_q <= !rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= job_in;
	end

endmodule
`default_nettype wire

// ----- rtl/cslf_norm.sv -----
`default_nettype none
module cslf_norm (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  cslf_pkg::wide_t      vec [3],
	output cslf_pkg::norm_rsp_t  rsp,
	output cslf_pkg::q14_t       dir [3]
);
	import cslf_pkg::*;

	norm_state_t state_q, state_nxt;
	logic [61:0] m_q   [3];
	logic        neg_q [3];
	logic [47:0] rem_q [3];
	logic [15:0] q_q   [3];
	logic [61:0] sum_q;
	logic [61:0] sum_nxt;
	logic [63:0] x_q, res_q, bit_q;
	logic [63:0] trial;
	logic [47:0] dv_q;
	logic [1:0]  k_q;
	logic [3:0]  bc_q;
	logic        zero_q;
	logic [61:0] big;

	always_comb begin
		big = m_q[0];
		if (m_q[1] > big) big = m_q[1];
		if (m_q[2] > big) big = m_q[2];
		sum_nxt = sum_q + 62'(m_q[k_q][29:0] * m_q[k_q][29:0]);
		trial   = res_q + bit_q;
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			N_IDLE:  if (start) state_nxt = N_SHIFT;
			N_SHIFT: begin
				if (big == '0) state_nxt = N_DONE;
				else if (big[61:30] == '0 && big[29]) state_nxt = N_SQ;
			end
			N_SQ:    if (k_q == 2'd2) state_nxt = N_ROOT;
			N_ROOT:  if (bit_q == 64'd1) state_nxt = N_DSET;
			N_DSET:  state_nxt = N_DIV;
			N_DIV:   if (bc_q == 4'd0) state_nxt = N_DONE;
			N_DONE:  state_nxt = N_IDLE;
			default: state_nxt = N_IDLE;
		endcase
	end

	always_comb begin
		rsp.done = (state_q == N_DONE);
		rsp.zero = zero_q;
		for (int j = 0; j < 3; j++) begin
			dir[j] = neg_q[j] ? 16'(-q_q[j]) : q_q[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			k_q     <= 2'd0;
			bc_q    <= 4'd0;
			zero_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			unique case (state_q)
				N_IDLE:  begin
					zero_q <= 1'b0;
					k_q    <= 2'd0;
				end
				N_SHIFT: if (big == '0) zero_q <= 1'b1;
				N_SQ:    k_q <= k_q + 2'd1;
				N_DSET:  bc_q <= 4'd15;
				N_DIV:   bc_q <= bc_q - 4'd1;
				N_ROOT, N_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			N_IDLE: if (start) begin
				for (int j = 0; j < 3; j++) begin
					m_q[j]   <= vec[j][63] ? 62'(-vec[j]) : 62'(vec[j]);
					neg_q[j] <= vec[j][63];
				end
				sum_q <= '0;
			end
			N_SHIFT: begin
				// bring the largest magnitude into [2^29, 2^30), one bit a cycle
				if (big == '0) begin
					for (int j = 0; j < 3; j++) q_q[j] <= '0;
				end else if (big[61:30] != '0) begin
					for (int j = 0; j < 3; j++) m_q[j] <= m_q[j] >> 1;
				end else if (!big[29]) begin
					for (int j = 0; j < 3; j++) m_q[j] <= m_q[j] << 1;
				end
			end
			N_SQ: begin
				sum_q <= sum_nxt;
				if (k_q == 2'd2) begin
					x_q   <= 64'(sum_nxt);
					res_q <= '0;
					bit_q <= 64'd1 << 62;
				end
			end
			N_ROOT: begin
				// bit-serial integer square root
				if (x_q >= trial) begin
					x_q   <= x_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			N_DSET: begin
				dv_q <= {res_q[32:0], 15'd0};
				for (int j = 0; j < 3; j++) begin
					rem_q[j] <= {4'd0, m_q[j][29:0], 14'd0} + 48'(res_q >> 1);
					q_q[j]   <= '0;
				end
			end
			N_DIV: begin
				// restoring divide, three lanes, one quotient bit a cycle
				for (int j = 0; j < 3; j++) begin
					if (rem_q[j] >= dv_q) begin
						rem_q[j]     <= rem_q[j] - dv_q;
						q_q[j][bc_q] <= 1'b1;
					end
				end
				dv_q <= dv_q >> 1;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/cslf_exec.sv -----
`default_nettype none
module cslf_exec (
	input  wire                  clk,
	input  wire                  arst_n,
	input  cslf_pkg::cfg_t       cfg,
	input  wire                  job_valid,
	input  cslf_pkg::job_t       job,
	output logic                 pop,
	output logic                 norm_start,
	output cslf_pkg::wide_t      norm_vec [3],
	input  cslf_pkg::norm_rsp_t  norm_rsp,
	input  cslf_pkg::q14_t       norm_dir [3],
	output logic                 done,
	output cslf_pkg::out_item_t  result
);
	import cslf_pkg::*;

	exec_state_t state_q, state_nxt;
	phase_t      phase_q;
	logic [1:0]  k_q;
	logic [1:0]  status_q;
	logic        mode_q;
	logic signed [32:0] d_q  [3];
	q14_t               v1_q [3];
	q14_t               v2_q [3];
	q14_t               v3_q [3];
	wide_t              t_q  [3];
	wide_t              ax   [3];
	logic signed [50:0] acc_q;
	logic signed [39:0] s_q;
	logic signed [48:0] nn_q, dd_q;
	logic signed [48:0] p_dot;
	logic signed [55:0] p_prj;
	logic signed [48:0] nn_p, dd_p;
	logic signed [32:0] cr [3];
	wide_t              p_tv;
	logic [15:0]        v1z_mag;
	logic [48:0]        dd_mag;
	logic               trip;

	function automatic wide_t round_shr14(input wide_t x);
		logic [63:0] m;
		m = x[63] ? -x : x;
		m = (m + 64'd8192) >> 14;
		return x[63] ? -m : m;
	endfunction

	always_comb begin
		ax[0] = 64'(cfg.axis_x);
		ax[1] = 64'(cfg.axis_y);
		ax[2] = 64'(cfg.axis_z);
		for (int j = 0; j < 3; j++) norm_vec[j] = t_q[j];
		p_dot = v2_q[k_q] * d_q[k_q];
		p_prj = v2_q[k_q] * s_q;
		nn_p  = v1_q[0] * cfg.axis_z - v1_q[2] * cfg.axis_x;
		dd_p  = v1_q[1] * cfg.axis_z - v1_q[2] * cfg.axis_y;
		cr[0] = v1_q[1] * v2_q[2] - v1_q[2] * v2_q[1];
		cr[1] = v1_q[2] * v2_q[0] - v1_q[0] * v2_q[2];
		cr[2] = v1_q[0] * v2_q[1] - v1_q[1] * v2_q[0];
		case (k_q)
			2'd0:    p_tv = dd_q * v1_q[2];
			2'd1:    p_tv = -(nn_q * v1_q[2]);
			2'd2:    p_tv = nn_q * v1_q[1];
			default: p_tv = t_q[2] - dd_q * v1_q[0];
		endcase
		v1z_mag = v1_q[2][15] ? 16'(-v1_q[2]) : v1_q[2];
		dd_mag  = dd_q[48] ? 49'(-dd_q) : dd_q;
		trip    = (v1z_mag <= {1'b0, cfg.lim}) || (dd_mag <= {18'd0, cfg.lim, 16'd0});
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			EX_IDLE:   if (job_valid) state_nxt = job.axis_zero ? EX_DONE : EX_LAUNCH;
			EX_LAUNCH: state_nxt = EX_WAIT;
			EX_WAIT:   if (norm_rsp.done) begin
				unique case (phase_q)
					PH_AXIS_C: state_nxt = EX_DOT;
					PH_SPH1:   state_nxt = EX_ND;
					PH_THIRD:  state_nxt = EX_DONE;
					PH_RAD, PH_SPH2: state_nxt = EX_CRS;
					default:   state_nxt = EX_IDLE;
				endcase
			end
			EX_DOT:    if (k_q == 2'd2) state_nxt = EX_SCL;
			EX_SCL:    state_nxt = EX_PROJ;
			EX_PROJ:   if (k_q == 2'd2) state_nxt = EX_LAUNCH;
			EX_CRS:    state_nxt = EX_LAUNCH;
			EX_ND:     if (k_q == 2'd1) state_nxt = EX_TST;
			EX_TST:    state_nxt = trip ? EX_LAUNCH : EX_TV;
			EX_TV:     if (k_q == 2'd3) state_nxt = EX_NEG;
			EX_NEG:    state_nxt = EX_LAUNCH;
			EX_DONE:   state_nxt = EX_IDLE;
			default:   state_nxt = EX_IDLE;
		endcase
	end

	always_comb begin
		pop        = (state_q == EX_IDLE) && job_valid;
		norm_start = (state_q == EX_LAUNCH);
		done       = (state_q == EX_DONE);
		result.first_x      = v1_q[0];
		result.first_y      = v1_q[1];
		result.first_z      = v1_q[2];
		result.second_x     = v2_q[0];
		result.second_y     = v2_q[1];
		result.second_z     = v2_q[2];
		result.third_x      = v3_q[0];
		result.third_y      = v3_q[1];
		result.third_z      = v3_q[2];
		result.frame_status = status_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= EX_IDLE;
			phase_q  <= PH_AXIS_C;
			k_q      <= 2'd0;
			status_q <= ST_OK;
			mode_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			unique case (state_q)
				EX_IDLE: if (job_valid) begin
					mode_q   <= job.mode;
					k_q      <= 2'd0;
					status_q <= job.axis_zero ? ST_AXIS_ZERO : ST_OK;
					phase_q  <= job.mode ? PH_SPH1 : PH_AXIS_C;
				end
				EX_WAIT: if (norm_rsp.done) begin
					k_q <= 2'd0;
					if (norm_rsp.zero && phase_q != PH_AXIS_C) status_q <= ST_DEGEN;
				end
				EX_DOT:  k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				EX_SCL:  k_q <= 2'd0;
				EX_PROJ: begin
					k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
					if (k_q == 2'd2) phase_q <= PH_RAD;
				end
				EX_CRS:  phase_q <= PH_THIRD;
				EX_ND:   k_q <= (k_q == 2'd1) ? 2'd0 : k_q + 2'd1;
				EX_TST:  begin
					k_q <= 2'd0;
					if (trip) phase_q <= PH_SPH2;
				end
				EX_TV:   k_q <= k_q + 2'd1;
				EX_NEG:  phase_q <= PH_SPH2;
				EX_LAUNCH, EX_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			EX_IDLE: if (job_valid) begin
				d_q[0] <= job.dx;
				d_q[1] <= job.dy;
				d_q[2] <= job.dz;
				for (int j = 0; j < 3; j++) begin
					v1_q[j] <= '0;
					v2_q[j] <= '0;
					v3_q[j] <= '0;
					t_q[j]  <= job.mode ? 64'(j == 0 ? job.dx : (j == 1 ? job.dy : job.dz))
					                    : ax[j];
				end
			end
			EX_WAIT: if (norm_rsp.done) begin
				acc_q <= '0;
				for (int j = 0; j < 3; j++) begin
					case (phase_q)
						PH_AXIS_C, PH_SPH2: v2_q[j] <= norm_dir[j];
						PH_RAD, PH_SPH1:    v1_q[j] <= norm_dir[j];
						default:            v3_q[j] <= norm_dir[j];
					endcase
				end
			end
			// projection length along the unit axis
			EX_DOT:  acc_q <= acc_q + 51'(p_dot);
			EX_SCL:  s_q   <= 40'(round_shr14(64'(acc_q)));
			EX_PROJ: t_q[k_q] <= 64'(d_q[k_q]) - round_shr14(64'(p_prj));
			EX_CRS:  for (int j = 0; j < 3; j++) t_q[j] <= 64'(cr[j]);
			EX_ND:   if (k_q == 2'd0) nn_q <= nn_p; else dd_q <= dd_p;
			EX_TST:  if (trip) for (int j = 0; j < 3; j++) t_q[j] <= ax[j];
			EX_TV:   t_q[(k_q == 2'd3) ? 2'd2 : k_q] <= p_tv;
			EX_NEG:  if (t_q[0][63]) for (int j = 0; j < 3; j++) t_q[j] <= -t_q[j];
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/cyl_sph_local_frame.sv -----
// channel    | handshake                     | payload
// -----------+-------------------------------+-------------------------------
// request in | start / busy (start & !busy)   | item   (in_item_t, Q16.16)
// result out | done, one-cycle strobe        | result (out_item_t, Q2.14)
// config     | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// each request needs up to three normalizations on the shared normalize unit,
// each a shift, squares, root and divide (a zero vector stops after the shift);
// a zero configured axis sends the request straight to done
// done is raised in the cycle after the back end finishes a request
// a two-entry queue takes new requests while the back end works; busy is high
// only while it is full
// arst_n clears control state; config registers reset to their defaults
// results cannot be stalled: done is a single-cycle strobe
`default_nettype none
module cyl_sph_local_frame (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  cslf_pkg::in_item_t   item,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire [2:0]            cfg_index,
	input  wire [31:0]           cfg_data,
	output logic                 done,
	output cslf_pkg::out_item_t  result
);
	import cslf_pkg::*;

	cfg_t      cfg_q;
	job_t      job;
	logic      job_valid;
	logic      pop;
	logic      norm_start;
	wide_t     norm_vec [3];
	norm_rsp_t norm_rsp;
	q14_t      norm_dir [3];
	logic      ex_done;
	out_item_t ex_result;

	// config writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode     <= 1'b0;
			cfg_q.axis_x   <= '0;
			cfg_q.axis_y   <= '0;
			cfg_q.axis_z   <= 32'sd65536;
			cfg_q.origin_x <= '0;
			cfg_q.origin_y <= '0;
			cfg_q.origin_z <= '0;
			cfg_q.lim      <= 15'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRAME_MODE: cfg_q.mode     <= cfg_data[0];
				REG_AXIS_X:     cfg_q.axis_x   <= cfg_data;
				REG_AXIS_Y:     cfg_q.axis_y   <= cfg_data;
				REG_AXIS_Z:     cfg_q.axis_z   <= cfg_data;
				REG_ORIGIN_X:   cfg_q.origin_x <= cfg_data;
				REG_ORIGIN_Y:   cfg_q.origin_y <= cfg_data;
				REG_ORIGIN_Z:   cfg_q.origin_z <= cfg_data;
				REG_NEAR_ZERO:  cfg_q.lim      <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

	// front: accept, classify, queue
	cslf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.cfg       (cfg_q),
		.pop       (pop),
		.job       (job),
		.job_valid (job_valid)
	);

	// back: sequencer over dot, projection, cross and tolerance test
	cslf_exec u_exec (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.job_valid  (job_valid),
		.job        (job),
		.pop        (pop),
		.norm_start (norm_start),
		.norm_vec   (norm_vec),
		.norm_rsp   (norm_rsp),
		.norm_dir   (norm_dir),
		.done       (ex_done),
		.result     (ex_result)
	);

	// shared normalize unit
	cslf_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start),
		.vec    (norm_vec),
		.rsp    (norm_rsp),
		.dir    (norm_dir)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ex_done;
		end
	end

	always_ff @(posedge clk) begin
		if (ex_done) result <= ex_result;
	end

endmodule
`default_nettype wire

// ----- rtl/cslf_checker.sv -----
`default_nettype none
module cslf_checker (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  cfg_valid,
	input wire                  cfg_ready,
	input wire                  done,
	input cslf_pkg::out_item_t  result
);
	import cslf_pkg::*;

	a_cfg_taken: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write not taken");

	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back results");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.frame_status == ST_OK || result.frame_status == ST_AXIS_ZERO ||
		          result.frame_status == ST_DEGEN))
		else $error("bad status code");

	a_axis_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.frame_status == ST_AXIS_ZERO) |->
		(result.first_x == 0 && result.first_y == 0 && result.first_z == 0 &&
		 result.second_x == 0 && result.second_y == 0 && result.second_z == 0 &&
		 result.third_x == 0 && result.third_y == 0 && result.third_z == 0))
		else $error("zero axis gave nonzero frame");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.first_x <= UNIT_Q14 && result.first_x >= -UNIT_Q14 &&
		          result.second_z <= UNIT_Q14 && result.second_z >= -UNIT_Q14 &&
		          result.third_y <= UNIT_Q14 && result.third_y >= -UNIT_Q14))
		else $error("component beyond unit length");

endmodule

bind cyl_sph_local_frame cslf_checker u_cslf_checker (.*);
`default_nettype wire
